[rtl/rph_pkg.sv]
// Shared types, constants and saturation helpers for the ray primitive hit test.
package rph_pkg;

  typedef logic signed [63:0] val_t;
  typedef logic signed [32:0] diff_t;

  localparam val_t INNER_MAX = (64'sd1 <<< 61) - 64'sd1;

  localparam logic CMD_SPHERE  = 1'b0;
  localparam logic CMD_SEGMENT = 1'b1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_DEPTH_RADIUS_SCALE,
    REG_MIN_LINE_RADIUS
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef struct packed {
    logic               command;
    logic signed [31:0] point_a_x;
    logic signed [31:0] point_a_y;
    logic signed [31:0] point_a_z;
    logic signed [31:0] point_b_x;
    logic signed [31:0] point_b_y;
    logic signed [31:0] point_b_z;
    logic [30:0]        sphere_radius;
    logic [30:0]        start_depth;
    logic [30:0]        end_depth;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        ray_distance;
    logic [16:0]        segment_param;
    logic [30:0]        miss_distance;
    logic signed [31:0] hit_point_x;
    logic signed [31:0] hit_point_y;
    logic signed [31:0] hit_point_z;
  } result_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        depth_radius_scale;
    logic [30:0]        min_line_radius;
  } ray_cfg_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] pa_x;
    logic signed [31:0] pa_y;
    logic signed [31:0] pa_z;
    diff_t              x_x;
    diff_t              x_y;
    diff_t              x_z;
    diff_t              w_x;
    diff_t              w_y;
    diff_t              w_z;
    logic [30:0]        radius;
    logic [30:0]        start_depth;
    logic [30:0]        end_depth;
  } job_t;

  typedef struct packed {
    logic    start;
    alu_op_e op;
    val_t    a;
    val_t    b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    val_t result;
  } alu_rsp_t;

  function automatic val_t sat(val_t x);
    if (x > INNER_MAX) begin
      return INNER_MAX;
    end else if (x < -INNER_MAX) begin
      return -INNER_MAX;
    end
    return x;
  endfunction

  function automatic logic [63:0] mag(val_t x);
    val_t n;
    n = -x;
    return (x < 0) ? 64'(n) : 64'(x);
  endfunction

  function automatic logic [30:0] out_u31(val_t x);
    if (x < 0) begin
      return '0;
    end else if (x > 64'sh7FFF_FFFF) begin
      return '1;
    end
    return x[30:0];
  endfunction

  function automatic logic [31:0] out_s32(val_t x);
    if (x > 64'sh7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (x < -64'sh8000_0000) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

[rtl/rph_stream_if.sv]
// Valid/ready stream channel carrying one payload per transaction.
interface rph_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rph_front.sv]
// Front end: accepts primitives, classifies them and forms the vector differences.
module rph_front import rph_pkg::*; (
  input  ray_cfg_t cfg_i,
  input  logic     item_valid_i,
  output logic     item_ready_o,
  input  item_t    item_i,
  input  logic     full_i,
  output logic     push_o,
  output job_t     job_o
);

  function automatic diff_t sub33(logic signed [31:0] p, logic signed [31:0] q);
    return 33'(p) - 33'(q);
  endfunction

  assign item_ready_o = !full_i;
  assign push_o       = item_valid_i && !full_i;

  always_comb begin
    job_o.command     = item_i.command;
    job_o.pa_x        = item_i.point_a_x;
    job_o.pa_y        = item_i.point_a_y;
    job_o.pa_z        = item_i.point_a_z;
    job_o.radius      = item_i.sphere_radius;
    job_o.start_depth = item_i.start_depth;
    job_o.end_depth   = item_i.end_depth;
    job_o.w_x         = sub33(cfg_i.origin_x, item_i.point_a_x);
    job_o.w_y         = sub33(cfg_i.origin_y, item_i.point_a_y);
    job_o.w_z         = sub33(cfg_i.origin_z, item_i.point_a_z);
    if (item_i.command == CMD_SEGMENT) begin
      job_o.x_x = sub33(item_i.point_b_x, item_i.point_a_x);
      job_o.x_y = sub33(item_i.point_b_y, item_i.point_a_y);
      job_o.x_z = sub33(item_i.point_b_z, item_i.point_a_z);
    end else begin
      job_o.x_x = sub33(item_i.point_a_x, cfg_i.origin_x);
      job_o.x_y = sub33(item_i.point_a_y, cfg_i.origin_y);
      job_o.x_z = sub33(item_i.point_a_z, cfg_i.origin_z);
    end
  end

endmodule

[rtl/rph_queue.sv]
// Two-entry job queue between the front end and the back end.
module rph_queue import rph_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[rtl/rph_alu.sv]
// Shared iterative arithmetic unit: fixed-point multiply, divide and square root.
module rph_alu import rph_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam int unsigned NLEN  = 64 + FRAC_BITS;
  localparam int unsigned SLEN  = NLEN + (NLEN % 2);
  localparam int unsigned CNT_W = $clog2(NLEN + 1);

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_MFIN, A_DIV, A_SQRT} state_e;

  state_e             state_q;
  logic               done_q;
  val_t               result_q;
  logic               neg_q;
  logic [63:0]        ua_q, ub_q;
  logic [63:0]        prod_q;
  logic [1:0]         pidx_q;
  logic               pv_q;
  logic [2:0]         j_q;
  logic [127:0]       acc_q;
  logic [NLEN-1:0]    shn_q;
  logic [SLEN-1:0]    shs_q;
  logic [63:0]        den_q, rem_q, quo_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [31:0]  pa, pb;
  logic [127:0] acc_d;
  logic [127:0] prod_ext;
  val_t         mul_m;
  logic [63:0]  dr1, drem, dq1;
  logic         dge;
  val_t         dq_s;
  logic [63:0]  sr1, strial, srem, sroot;
  logic         sge;

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

  always_comb begin
    pa       = j_q[1] ? ua_q[63:32] : ua_q[31:0];
    pb       = j_q[0] ? ub_q[63:32] : ub_q[31:0];
    prod_ext = {64'd0, prod_q};
    case (pidx_q)
      2'd0:    acc_d = acc_q + prod_ext;
      2'd3:    acc_d = acc_q + (prod_ext << 64);
      default: acc_d = acc_q + (prod_ext << 32);
    endcase
    if (|acc_q[127:FRAC_BITS+61]) begin
      mul_m = INNER_MAX;
    end else begin
      mul_m = val_t'({3'd0, acc_q[FRAC_BITS+60:FRAC_BITS]});
    end

    dr1  = {rem_q[62:0], shn_q[NLEN-1]};
    dge  = (dr1 >= den_q);
    drem = dge ? dr1 - den_q : dr1;
    dq1  = {quo_q[62:0], dge};
    dq_s = (dq1 > 64'(INNER_MAX)) ? INNER_MAX : val_t'(dq1);

    sr1    = {rem_q[61:0], shs_q[SLEN-1:SLEN-2]};
    strial = {quo_q[61:0], 2'b01};
    sge    = (sr1 >= strial);
    srem   = sge ? sr1 - strial : sr1;
    sroot  = {quo_q[62:0], sge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      pv_q    <= 1'b0;
      j_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            case (req_i.op)
              OP_MUL: begin
                ua_q    <= mag(req_i.a);
                ub_q    <= mag(req_i.b);
                neg_q   <= (req_i.a < 0) != (req_i.b < 0);
                acc_q   <= '0;
                j_q     <= '0;
                pv_q    <= 1'b0;
                state_q <= A_MUL;
              end
              OP_DIV: begin
                shn_q   <= {mag(req_i.a), {FRAC_BITS{1'b0}}};
                den_q   <= 64'(req_i.b);
                rem_q   <= '0;
                quo_q   <= '0;
                neg_q   <= (req_i.a < 0);
                cnt_q   <= CNT_W'(NLEN);
                state_q <= A_DIV;
              end
              OP_SQRT: begin
                if (req_i.a <= 0) begin
                  result_q <= '0;
                  done_q   <= 1'b1;
                end else begin
                  shs_q   <= SLEN'({req_i.a, {FRAC_BITS{1'b0}}});
                  rem_q   <= '0;
                  quo_q   <= '0;
                  cnt_q   <= CNT_W'(SLEN / 2);
                  state_q <= A_SQRT;
                end
              end
              default: begin
                result_q <= '0;
                done_q   <= 1'b1;
              end
            endcase
          end
        end
        A_MUL: begin
          if (j_q != 3'd4) begin
            prod_q <= pa * pb;
            pidx_q <= j_q[1:0];
            pv_q   <= 1'b1;
          end else begin
            pv_q    <= 1'b0;
            state_q <= A_MFIN;
          end
          if (pv_q) begin
            acc_q <= acc_d;
          end
          j_q <= j_q + 3'd1;
        end
        A_MFIN: begin
          result_q <= neg_q ? -mul_m : mul_m;
          done_q   <= 1'b1;
          state_q  <= A_IDLE;
        end
        A_DIV: begin
          rem_q <= drem;
          quo_q <= dq1;
          shn_q <= shn_q << 1;
          cnt_q <= cnt_q - CNT_W'(1);
          if (dq1 > 64'(INNER_MAX) || cnt_q == CNT_W'(1)) begin
            result_q <= neg_q ? -dq_s : dq_s;
            done_q   <= 1'b1;
            state_q  <= A_IDLE;
          end
        end
        A_SQRT: begin
          rem_q <= srem;
          quo_q <= sroot;
          shs_q <= shs_q << 2;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            result_q <= val_t'(sroot);
            done_q   <= 1'b1;
            state_q  <= A_IDLE;
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

endmodule

[rtl/rph_back.sv]
// Back end: sequences the sphere and segment tests on the shared arithmetic unit.
module rph_back import rph_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ray_cfg_t cfg_i,
  input  logic     empty_i,
  input  job_t     job_i,
  output logic     pop_o,
  output alu_req_t alu_req_o,
  input  alu_rsp_t alu_rsp_i,
  output logic     result_valid_o,
  input  logic     result_ready_i,
  output result_t  result_o
);

  localparam val_t ONE = 64'sd1 <<< FRAC_BITS;
  localparam int unsigned SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int unsigned SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [1:0] LAST_LANE = 2'd2;

  typedef enum logic [1:0] {B_IDLE, B_ISSUE, B_WAIT, B_OUT} state_e;

  typedef enum logic [4:0] {
    SPH_PROJ, SPH_TT, SPH_PP, SPH_RSQ, SPH_HALF, SPH_HP,
    SEG_AA, SEG_BB, SEG_CC, SEG_DD, SEG_EE, SEG_AC, SEG_BB2, SEG_T0,
    SEG_SN1, SEG_SN2, SEG_SDIV, SEG_TN1, SEG_TN2, SEG_TDIV,
    SEG_SN3, SEG_SDIV2, SEG_ONR, SEG_HP, SEG_DL, SEG_MISS, SEG_DEPTH, SEG_RAD
  } step_e;

  function automatic val_t clamp_t(val_t x);
    if (x < 0) begin
      return '0;
    end else if (x > ONE) begin
      return ONE;
    end
    return x;
  endfunction

  state_e     state_q;
  step_e      step_q;
  logic [1:0] lane_q;
  job_t       job_q;
  val_t       acc_q, proj_q, perp_q, rsq_q, dist_q, miss_q, tmp_q;
  val_t       aa_q, bb_q, cc_q, dd_q, ee_q, den_q, t0_q, s_q, t_q;
  val_t       hp_q [3];
  val_t       onr_q [3];
  logic       hit_q;
  logic       out_valid_q;
  result_t    out_q;

  val_t    o_v [3];
  val_t    d_v [3];
  val_t    a_v [3];
  val_t    x_v [3];
  val_t    w_v [3];
  val_t    dl_v [3];
  val_t    ok, dk, ak, xk, wk, dlk;
  val_t    rad, sd, ed, minr;
  alu_op_e op;
  val_t    opa, opb;
  logic    wb;
  val_t    r;
  val_t    acc_next, dot_v;
  val_t    dist_lo, dist_hi, dist_sel, radius;
  logic [63:0] tu;

  always_comb begin
    o_v[0] = 64'(cfg_i.origin_x);
    o_v[1] = 64'(cfg_i.origin_y);
    o_v[2] = 64'(cfg_i.origin_z);
    d_v[0] = 64'(cfg_i.dir_x);
    d_v[1] = 64'(cfg_i.dir_y);
    d_v[2] = 64'(cfg_i.dir_z);
    a_v[0] = 64'(job_q.pa_x);
    a_v[1] = 64'(job_q.pa_y);
    a_v[2] = 64'(job_q.pa_z);
    x_v[0] = 64'(job_q.x_x);
    x_v[1] = 64'(job_q.x_y);
    x_v[2] = 64'(job_q.x_z);
    w_v[0] = 64'(job_q.w_x);
    w_v[1] = 64'(job_q.w_y);
    w_v[2] = 64'(job_q.w_z);
    for (int k = 0; k < 3; k++) begin
      dl_v[k] = onr_q[k] - hp_q[k];
    end
    ok   = o_v[lane_q];
    dk   = d_v[lane_q];
    ak   = a_v[lane_q];
    xk   = x_v[lane_q];
    wk   = w_v[lane_q];
    dlk  = dl_v[lane_q];
    rad  = val_t'({33'd0, job_q.radius});
    sd   = val_t'({33'd0, job_q.start_depth});
    ed   = val_t'({33'd0, job_q.end_depth});
    minr = val_t'({33'd0, cfg_i.min_line_radius});
  end

  always_comb begin
    op  = OP_MUL;
    opa = '0;
    opb = '0;
    case (step_q)
      SPH_PROJ:  begin opa = xk; opb = dk; end
      SPH_TT:    begin opa = xk; opb = xk; end
      SPH_PP:    begin opa = proj_q; opb = proj_q; end
      SPH_RSQ:   begin opa = rad; opb = rad; end
      SPH_HALF:  begin op = OP_SQRT; opa = rsq_q - perp_q; end
      SPH_HP:    begin opa = dk; opb = dist_q; end
      SEG_AA:    begin opa = dk; opb = dk; end
      SEG_BB:    begin opa = dk; opb = xk; end
      SEG_CC:    begin opa = xk; opb = xk; end
      SEG_DD:    begin opa = dk; opb = wk; end
      SEG_EE:    begin opa = xk; opb = wk; end
      SEG_AC:    begin opa = aa_q; opb = cc_q; end
      SEG_BB2:   begin opa = bb_q; opb = bb_q; end
      SEG_T0:    begin
        op  = (cc_q > 0) ? OP_DIV : OP_NONE;
        opa = ee_q;
        opb = cc_q;
      end
      SEG_SN1:   begin
        op  = (den_q > 0) ? OP_MUL : OP_NONE;
        opa = bb_q;
        opb = ee_q;
      end
      SEG_SN2:   begin opa = cc_q; opb = dd_q; end
      SEG_SDIV:  begin op = OP_DIV; opa = tmp_q; opb = den_q; end
      SEG_TN1:   begin opa = aa_q; opb = ee_q; end
      SEG_TN2:   begin opa = bb_q; opb = dd_q; end
      SEG_TDIV:  begin op = OP_DIV; opa = tmp_q; opb = den_q; end
      SEG_SN3:   begin opa = bb_q; opb = t_q; end
      SEG_SDIV2: begin
        op  = (aa_q > 0) ? OP_DIV : OP_NONE;
        opa = tmp_q;
        opb = aa_q;
      end
      SEG_ONR:   begin opa = dk; opb = s_q; end
      SEG_HP:    begin opa = xk; opb = t_q; end
      SEG_DL:    begin opa = dlk; opb = dlk; end
      SEG_MISS:  begin op = OP_SQRT; opa = tmp_q; end
      SEG_DEPTH: begin opa = ed - sd; opb = t_q; end
      SEG_RAD:   begin opa = val_t'({33'd0, cfg_i.depth_radius_scale}); opb = tmp_q; end
      default:   op = OP_NONE;
    endcase
  end

  assign alu_req_o.start = (state_q == B_ISSUE) && (op != OP_NONE);
  assign alu_req_o.op    = op;
  assign alu_req_o.a     = opa;
  assign alu_req_o.b     = opb;

  always_comb begin
    wb       = ((state_q == B_ISSUE) && (op == OP_NONE)) ||
               ((state_q == B_WAIT) && alu_rsp_i.done);
    r        = (state_q == B_WAIT) ? alu_rsp_i.result : '0;
    acc_next = (lane_q == 2'd0) ? r : acc_q + r;
    dot_v    = sat(acc_next);
    dist_lo  = sat(proj_q - r);
    dist_hi  = sat(proj_q + r);
    dist_sel = (dist_lo < 0) ? dist_hi : dist_lo;
    radius   = (r < minr) ? minr : r;
    tu       = (64'(t_q) >> SH_R) << SH_L;
  end

  assign pop_o          = (state_q == B_IDLE) && !empty_i;
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= SPH_PROJ;
      lane_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && result_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            job_q   <= job_i;
            acc_q   <= '0;
            hit_q   <= 1'b0;
            dist_q  <= '0;
            miss_q  <= '0;
            t_q     <= '0;
            s_q     <= '0;
            for (int k = 0; k < 3; k++) begin
              hp_q[k] <= '0;
            end
            lane_q  <= 2'd0;
            step_q  <= (job_i.command == CMD_SEGMENT) ? SEG_AA : SPH_PROJ;
            state_q <= B_ISSUE;
          end
        end
        B_ISSUE: begin
          if (op != OP_NONE) begin
            state_q <= B_WAIT;
          end
        end
        B_OUT: begin
          if (!out_valid_q || result_ready_i) begin
            out_valid_q         <= 1'b1;
            out_q.hit           <= hit_q;
            out_q.ray_distance  <= out_u31(dist_q);
            out_q.segment_param <= tu[16:0];
            out_q.miss_distance <= out_u31(miss_q);
            out_q.hit_point_x   <= out_s32(hp_q[0]);
            out_q.hit_point_y   <= out_s32(hp_q[1]);
            out_q.hit_point_z   <= out_s32(hp_q[2]);
            state_q             <= B_IDLE;
          end
        end
        default: ;
      endcase

      if (wb) begin
        state_q <= B_ISSUE;
        case (step_q)
          SPH_PROJ, SPH_TT, SEG_AA, SEG_BB, SEG_CC, SEG_DD, SEG_EE, SEG_DL: begin
            acc_q <= acc_next;
            if (lane_q != LAST_LANE) begin
              lane_q <= lane_q + 2'd1;
            end else begin
              lane_q <= 2'd0;
              case (step_q)
                SPH_PROJ: begin proj_q <= dot_v; step_q <= SPH_TT; end
                SPH_TT:   begin acc_q <= dot_v; step_q <= SPH_PP; end
                SEG_AA:   begin aa_q <= dot_v; step_q <= SEG_BB; end
                SEG_BB:   begin bb_q <= dot_v; step_q <= SEG_CC; end
                SEG_CC:   begin cc_q <= dot_v; step_q <= SEG_DD; end
                SEG_DD:   begin dd_q <= dot_v; step_q <= SEG_EE; end
                SEG_EE:   begin ee_q <= dot_v; step_q <= SEG_AC; end
                default:  begin tmp_q <= dot_v; step_q <= SEG_MISS; end
              endcase
            end
          end
          SPH_PP: begin
            perp_q <= sat(acc_q - r);
            step_q <= SPH_RSQ;
          end
          SPH_RSQ: begin
            rsq_q <= r;
            if (perp_q <= r) begin
              step_q <= SPH_HALF;
            end else begin
              state_q <= B_OUT;
            end
          end
          SPH_HALF: begin
            if (dist_sel >= 0) begin
              dist_q <= dist_sel;
              hit_q  <= 1'b1;
              step_q <= SPH_HP;
            end else begin
              state_q <= B_OUT;
            end
          end
          SPH_HP, SEG_ONR, SEG_HP: begin
            case (step_q)
              SPH_HP:  hp_q[lane_q] <= sat(ok + r);
              SEG_ONR: onr_q[lane_q] <= sat(ok + r);
              default: hp_q[lane_q] <= sat(ak + r);
            endcase
            if (lane_q != LAST_LANE) begin
              lane_q <= lane_q + 2'd1;
            end else begin
              lane_q <= 2'd0;
              case (step_q)
                SPH_HP:  state_q <= B_OUT;
                SEG_ONR: step_q <= SEG_HP;
                default: step_q <= SEG_DL;
              endcase
            end
          end
          SEG_AC: begin
            acc_q  <= r;
            step_q <= SEG_BB2;
          end
          SEG_BB2: begin
            den_q  <= sat(acc_q - r);
            step_q <= SEG_T0;
          end
          SEG_T0: begin
            t0_q   <= r;
            step_q <= SEG_SN1;
          end
          SEG_SN1: begin
            if (den_q > 0) begin
              acc_q  <= r;
              step_q <= SEG_SN2;
            end else begin
              s_q    <= '0;
              t_q    <= clamp_t(t0_q);
              step_q <= SEG_SN3;
            end
          end
          SEG_SN2: begin
            tmp_q  <= sat(acc_q - r);
            step_q <= SEG_SDIV;
          end
          SEG_SDIV: begin
            s_q    <= r;
            step_q <= SEG_TN1;
          end
          SEG_TN1: begin
            acc_q  <= r;
            step_q <= SEG_TN2;
          end
          SEG_TN2: begin
            tmp_q  <= sat(acc_q - r);
            step_q <= SEG_TDIV;
          end
          SEG_TDIV: begin
            t_q    <= clamp_t((s_q < 0) ? t0_q : r);
            step_q <= SEG_SN3;
          end
          SEG_SN3: begin
            tmp_q  <= sat(r - dd_q);
            step_q <= SEG_SDIV2;
          end
          SEG_SDIV2: begin
            s_q    <= (r < 0) ? '0 : r;
            step_q <= SEG_ONR;
          end
          SEG_MISS: begin
            miss_q <= r;
            step_q <= SEG_DEPTH;
          end
          SEG_DEPTH: begin
            tmp_q  <= sat(sd + r);
            step_q <= SEG_RAD;
          end
          SEG_RAD: begin
            hit_q   <= (miss_q <= radius);
            dist_q  <= s_q;
            state_q <= B_OUT;
          end
          default: state_q <= B_OUT;
        endcase
      end
    end
  end

endmodule

[rtl/ray_primitive_hit_test.sv]
// Ray versus sphere and segment hit test, top level.
//
// The ray origin, direction and the line tolerance terms are written through
// the register port (cfg_we_i, cfg_idx_i, cfg_data_i) while the block is idle.
// Each transaction on item_i carries one primitive, a sphere or a segment, and
// yields exactly one transaction on result_o, in order.
// The front end takes an item in any cycle the two-entry queue has room, so
// up to two items wait while the back end works on a third.
// The back end runs one item at a time on a shared iterative arithmetic unit
// that multiplies, divides and takes square roots; how long a segment takes
// depends on which divides run.
// Results sit in an output register; while result_o is stalled the back end
// holds its finished item and the queue keeps filling until full.
// Reset empties the queue, drops any item in flight and loads the register
// defaults: origin zero, direction +Z at unit length, tolerances zero.
module ray_primitive_hit_test import rph_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rph_stream_if.sink            item_i,
  rph_stream_if.source          result_o
);

  ray_cfg_t cfg_q;
  logic     full, empty, push, pop;
  job_t     job_in, job_head;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  result_t  result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q                    <= '0;
      cfg_q.dir_z              <= 32'(64'sd1 <<< FRAC_BITS);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ORIGIN_X:           cfg_q.origin_x <= cfg_data_i;
        REG_ORIGIN_Y:           cfg_q.origin_y <= cfg_data_i;
        REG_ORIGIN_Z:           cfg_q.origin_z <= cfg_data_i;
        REG_DIR_X:              cfg_q.dir_x <= cfg_data_i;
        REG_DIR_Y:              cfg_q.dir_y <= cfg_data_i;
        REG_DIR_Z:              cfg_q.dir_z <= cfg_data_i;
        REG_DEPTH_RADIUS_SCALE: cfg_q.depth_radius_scale <= cfg_data_i[30:0];
        REG_MIN_LINE_RADIUS:    cfg_q.min_line_radius <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  rph_front u_front (
    .cfg_i        (cfg_q),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .item_i       (item_i.data),
    .full_i       (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  rph_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_head)
  );

  rph_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  rph_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (empty),
    .job_i          (job_head),
    .pop_o          (pop),
    .alu_req_o      (alu_req),
    .alu_rsp_i      (alu_rsp),
    .result_valid_o (result_o.valid),
    .result_ready_i (result_o.ready),
    .result_o       (result)
  );

  assign result_o.data = result;

endmodule

[bench/ray_primitive_hit_test_tb.sv]
// Self-checking testbench for the ray versus sphere and segment hit test.
`timescale 1ns / 1ps

module ray_primitive_hit_test_tb;
  import rph_pkg::*;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_LIM = (64'sd1 <<< 61) - 64'sd1;
  localparam fx_t FX_ONE = 64'sd65536;
  localparam int unsigned SETTLE_CYCLES = 800;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam int unsigned NUM_PHASES = 6;

  typedef struct {
    item_t   item;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rph_stream_if #(.T(item_t)) item_if ();
  rph_stream_if #(.T(result_t)) result_if ();

  ray_primitive_hit_test dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  ray_cfg_t  ray_cfg;
  result_t   hit_q[$];
  int        errors;
  int        results_seen;
  int        hits_seen;
  int        segments_sent;
  bit        idle_on;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic fx_t clip(fx_t x);
    if (x > FX_LIM) return FX_LIM;
    if (x < -FX_LIM) return -FX_LIM;
    return x;
  endfunction

  function automatic logic [127:0] absw(fx_t x);
    logic [63:0] m;
    m = (x < 0) ? 64'(-x) : 64'(x);
    return {64'd0, m};
  endfunction

  function automatic fx_t fx_from(logic [127:0] m, bit neg);
    fx_t v;
    v = (m > 128'(FX_LIM)) ? FX_LIM : fx_t'(m[63:0]);
    return neg ? -v : v;
  endfunction

  function automatic fx_t fmul(fx_t a, fx_t b);
    logic [127:0] p;
    p = (absw(a) * absw(b)) >> 16;
    return fx_from(p, (a < 0) != (b < 0));
  endfunction

  function automatic fx_t fdiv(fx_t num, fx_t den);
    logic [127:0] q;
    q = (absw(num) << 16) / absw(den);
    return fx_from(q, num < 0);
  endfunction

  function automatic fx_t froot(fx_t x);
    logic [127:0] v;
    logic [127:0] root;
    logic [127:0] trial;
    if (x <= 0) return 0;
    v = absw(x) << 16;
    root = '0;
    for (int b = 40; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return fx_t'(root[63:0]);
  endfunction

  function automatic fx_t fdot(fx_t ax, fx_t ay, fx_t az, fx_t bx, fx_t by, fx_t bz);
    return clip(fmul(ax, bx) + fmul(ay, by) + fmul(az, bz));
  endfunction

  function automatic logic [30:0] to_u31(fx_t x);
    if (x < 0) return '0;
    if (x > 64'sh7FFF_FFFF) return '1;
    return x[30:0];
  endfunction

  function automatic logic [31:0] to_s32(fx_t x);
    if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic result_t predict_hit(item_t it);
    fx_t o[3], d[3], a[3], b[3], hp[3], v[3], w[3], onr[3], dl[3];
    fx_t ray_dist, t, miss, proj, perp, rsq, half;
    fx_t aa, bb, cc, dd, ee, den, s, sd, ed, depth, radius;
    bit  hit;
    result_t r;
    o[0] = fx_t'(ray_cfg.origin_x); o[1] = fx_t'(ray_cfg.origin_y);
    o[2] = fx_t'(ray_cfg.origin_z);
    d[0] = fx_t'(ray_cfg.dir_x); d[1] = fx_t'(ray_cfg.dir_y); d[2] = fx_t'(ray_cfg.dir_z);
    a[0] = fx_t'(it.point_a_x); a[1] = fx_t'(it.point_a_y); a[2] = fx_t'(it.point_a_z);
    b[0] = fx_t'(it.point_b_x); b[1] = fx_t'(it.point_b_y); b[2] = fx_t'(it.point_b_z);
    hp = '{0, 0, 0};
    ray_dist = 0; t = 0; miss = 0; s = 0; hit = 0;
    if (it.command == CMD_SPHERE) begin
      for (int i = 0; i < 3; i++) w[i] = a[i] - o[i];
      proj = fdot(w[0], w[1], w[2], d[0], d[1], d[2]);
      perp = clip(fdot(w[0], w[1], w[2], w[0], w[1], w[2]) - fmul(proj, proj));
      rsq = fmul(fx_t'(it.sphere_radius), fx_t'(it.sphere_radius));
      if (perp <= rsq) begin
        half = froot(rsq - perp);
        ray_dist = clip(proj - half);
        if (ray_dist < 0) ray_dist = clip(proj + half);
        hit = ray_dist >= 0;
      end
      if (hit) begin
        for (int i = 0; i < 3; i++) hp[i] = clip(o[i] + fmul(d[i], ray_dist));
      end else begin
        ray_dist = 0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        v[i] = b[i] - a[i];
        w[i] = o[i] - a[i];
      end
      aa = fdot(d[0], d[1], d[2], d[0], d[1], d[2]);
      bb = fdot(d[0], d[1], d[2], v[0], v[1], v[2]);
      cc = fdot(v[0], v[1], v[2], v[0], v[1], v[2]);
      dd = fdot(d[0], d[1], d[2], w[0], w[1], w[2]);
      ee = fdot(v[0], v[1], v[2], w[0], w[1], w[2]);
      den = clip(fmul(aa, cc) - fmul(bb, bb));
      t = (cc > 0) ? fdiv(ee, cc) : 0;
      if (den > 0) begin
        s = fdiv(clip(fmul(bb, ee) - fmul(cc, dd)), den);
        t = fdiv(clip(fmul(aa, ee) - fmul(bb, dd)), den);
      end
      if (s < 0) t = (cc > 0) ? fdiv(ee, cc) : 0;
      if (t < 0) t = 0;
      if (t > FX_ONE) t = FX_ONE;
      s = (aa > 0) ? fdiv(clip(fmul(bb, t) - dd), aa) : 0;
      if (s < 0) s = 0;
      for (int i = 0; i < 3; i++) begin
        onr[i] = clip(o[i] + fmul(d[i], s));
        hp[i] = clip(a[i] + fmul(v[i], t));
        dl[i] = onr[i] - hp[i];
      end
      miss = froot(fdot(dl[0], dl[1], dl[2], dl[0], dl[1], dl[2]));
      sd = fx_t'(it.start_depth);
      ed = fx_t'(it.end_depth);
      depth = clip(sd + fmul(ed - sd, t));
      radius = fmul(fx_t'(ray_cfg.depth_radius_scale), depth);
      if (radius < fx_t'(ray_cfg.min_line_radius)) radius = fx_t'(ray_cfg.min_line_radius);
      hit = miss <= radius;
      ray_dist = s;
    end
    r.hit = hit;
    r.ray_distance = to_u31(ray_dist);
    r.segment_param = t[16:0];
    r.miss_distance = to_u31(miss);
    r.hit_point_x = to_s32(hp[0]);
    r.hit_point_y = to_s32(hp[1]);
    r.hit_point_z = to_s32(hp[2]);
    return r;
  endfunction

  function automatic real rnd(real lo, real hi);
    return lo + (hi - lo) * ($itor($urandom) / 4294967295.0);
  endfunction

  function automatic logic [31:0] to_q(real x);
    real y;
    y = x * 65536.0;
    if (y > 2147483647.0) y = 2147483647.0;
    if (y < -2147483648.0) y = -2147483648.0;
    return 32'($rtoi(y));
  endfunction

  function automatic logic [30:0] to_uq(real x);
    logic [31:0] q;
    q = to_q(x < 0.0 ? 0.0 : x);
    return q[31] ? 31'h7FFF_FFFF : q[30:0];
  endfunction

  function automatic item_t noise_item();
    logic [287:0] raw;
    item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
    it = raw[285:0];
    return it;
  endfunction

  function automatic item_t shaped_item();
    real o[3], d[3], pa[3], pb[3];
    real t1, t2, spread;
    item_t it;
    o[0] = $itor(ray_cfg.origin_x) / 65536.0;
    o[1] = $itor(ray_cfg.origin_y) / 65536.0;
    o[2] = $itor(ray_cfg.origin_z) / 65536.0;
    d[0] = $itor(ray_cfg.dir_x) / 65536.0;
    d[1] = $itor(ray_cfg.dir_y) / 65536.0;
    d[2] = $itor(ray_cfg.dir_z) / 65536.0;
    spread = ($urandom_range(3) == 0) ? 8.0 : 1.0;
    t1 = rnd(-10.0, 60.0);
    t2 = ($urandom_range(5) == 0) ? t1 : rnd(-10.0, 60.0);
    for (int i = 0; i < 3; i++) begin
      pa[i] = o[i] + d[i] * t1 + rnd(-spread, spread);
      pb[i] = o[i] + d[i] * t2 + rnd(-spread, spread);
    end
    if ($urandom_range(7) == 0) pb = pa;
    it.command = 1'($urandom_range(1));
    it.point_a_x = to_q(pa[0]); it.point_a_y = to_q(pa[1]); it.point_a_z = to_q(pa[2]);
    it.point_b_x = to_q(pb[0]); it.point_b_y = to_q(pb[1]); it.point_b_z = to_q(pb[2]);
    it.sphere_radius = to_uq(rnd(0.0, 3.0 * spread));
    it.start_depth = to_uq(rnd(0.0, 100.0));
    it.end_depth = to_uq(rnd(0.0, 100.0));
    return it;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_ORIGIN_X: ray_cfg.origin_x = value;
      REG_ORIGIN_Y: ray_cfg.origin_y = value;
      REG_ORIGIN_Z: ray_cfg.origin_z = value;
      REG_DIR_X: ray_cfg.dir_x = value;
      REG_DIR_Y: ray_cfg.dir_y = value;
      REG_DIR_Z: ray_cfg.dir_z = value;
      REG_DEPTH_RADIUS_SCALE: ray_cfg.depth_radius_scale = value[30:0];
      REG_MIN_LINE_RADIUS: ray_cfg.min_line_radius = value[30:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                          logic [31:0] scale, logic [31:0] minr);
    while (hit_q.size() != 0) @(posedge clk_i);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_DEPTH_RADIUS_SCALE, scale);
    write_reg(REG_MIN_LINE_RADIUS, minr);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(item_t it, bit typed, result_t want);
    result_t exp_res;
    while (idle_on && $urandom_range(99) < 29) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data <= it;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    exp_res = typed ? want : predict_hit(it);
    hit_q.insert(hit_q.size(), exp_res);
    if (it.command == CMD_SEGMENT) segments_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      result_if.ready <= !(idle_on && $urandom_range(99) < 29);
    end
  end

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = result_if.data;
      results_seen++;
      if (got.hit === 1'b1) hits_seen++;
      if (hit_q.size() == 0) begin
        report("unexpected transaction", 64'(got), 64'd0);
      end else begin
        want = hit_q.pop_front();
        check_field("hit", 64'(got.hit), 64'(want.hit));
        check_field("ray_distance", 64'(got.ray_distance), 64'(want.ray_distance));
        check_field("segment_param", 64'(got.segment_param), 64'(want.segment_param));
        check_field("miss_distance", 64'(got.miss_distance), 64'(want.miss_distance));
        check_field("hit_point_x", 64'(got.hit_point_x), 64'(want.hit_point_x));
        check_field("hit_point_y", 64'(got.hit_point_y), 64'(want.hit_point_y));
        check_field("hit_point_z", 64'(got.hit_point_z), 64'(want.hit_point_z));
      end
    end
  end

  function automatic item_t mk(logic cmd, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                               logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                               logic [30:0] rad, logic [30:0] sd, logic [30:0] ed);
    item_t it;
    it = {cmd, ax, ay, az, bx, by, bz, rad, sd, ed};
    return it;
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    result_t   none;
    item_t     it;
    real       dx, dy, dz, n;
    none = '0;
    errors = 0;
    results_seen = 0;
    hits_seen = 0;
    segments_sent = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ORIGIN_X;
    cfg_data_i = '0;
    item_if.valid = 1'b0;
    item_if.data = '0;
    result_if.ready = 1'b0;
    ray_cfg = '0;
    ray_cfg.dir_z = FX_ONE[31:0];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hit in front at z = 9
    row.item = mk(CMD_SPHERE, 0, 0, 32'h000A_0000, 0, 0, 0, 31'h1_0000, 0, 0);
    row.typed = 1;
    row.want = '{1'b1, 31'h9_0000, 17'd0, 31'd0, 32'd0, 32'd0, 32'h0009_0000};
    rows.insert(rows.size(), row);
    // off axis miss and sphere behind the origin
    row.item = mk(CMD_SPHERE, 32'h0005_0000, 0, 32'h000A_0000, 0, 0, 0, 31'h1_0000, 0, 0);
    row.want = none;
    rows.insert(rows.size(), row);
    row.item = mk(CMD_SPHERE, 0, 0, 32'hFFF6_0000, 0, 0, 0, 31'h1_0000, 0, 0);
    rows.insert(rows.size(), row);
    row.typed = 0;
    row.want = none;
    // origin inside the sphere: far root
    row.item = mk(CMD_SPHERE, 0, 0, 32'h0000_8000, 0, 0, 0, 31'h2_0000, 0, 0);
    rows.insert(rows.size(), row);
    row.item = mk(CMD_SPHERE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    rows.insert(rows.size(), row);
    row.item = mk(CMD_SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                  31'h7FFF_FFFF, 0, 0);
    rows.insert(rows.size(), row);
    row.item = mk(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rows.insert(rows.size(), row);
    // segment crossing the ray
    row.item = mk(CMD_SEGMENT, 32'hFFFE_0000, 0, 32'h0005_0000, 32'h0002_0000, 0,
                  32'h0005_0000, 0, 31'h5_0000, 31'h5_0000);
    rows.insert(rows.size(), row);
    // degenerate segment
    row.item = mk(CMD_SEGMENT, 32'h0001_0000, 0, 32'h0003_0000, 32'h0001_0000, 0,
                  32'h0003_0000, 0, 31'h3_0000, 31'h3_0000);
    rows.insert(rows.size(), row);
    // parallel segment
    row.item = mk(CMD_SEGMENT, 32'h0000_1000, 0, 32'h0002_0000, 32'h0000_1000, 0,
                  32'h0008_0000, 0, 31'h2_0000, 31'h8_0000);
    rows.insert(rows.size(), row);
    // segment behind the origin, clamped ends
    row.item = mk(CMD_SEGMENT, 32'hFFFF_0000, 32'h0001_0000, 32'hFFF0_0000, 32'h0001_0000,
                  32'hFFFF_0000, 32'hFFE0_0000, 0, 31'h1_0000, 0);
    rows.insert(rows.size(), row);
    row.item = mk(CMD_SEGMENT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    rows.insert(rows.size(), row);
    row.item = mk(CMD_SEGMENT, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                  32'h8000_0000, 0, 0, 31'h7FFF_FFFF);
    rows.insert(rows.size(), row);
    row.item = mk(CMD_SEGMENT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rows.insert(rows.size(), row);

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);
    item_if.valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      @(posedge clk_i);
      idle_on = (ph != 1);
      dx = rnd(-1.0, 1.0); dy = rnd(-1.0, 1.0); dz = rnd(-1.0, 1.0);
      n = $sqrt(dx * dx + dy * dy + dz * dz) + 1.0e-6;
      case (ph)
        0: load_ray(0, 0, 0, 0, 0, FX_ONE[31:0], 0, 0);
        1: load_ray(to_q(rnd(-20.0, 20.0)), to_q(rnd(-20.0, 20.0)), to_q(rnd(-20.0, 20.0)),
                    to_q(dx / n), to_q(dy / n), to_q(dz / n), 32'd1311, 32'd3277);
        2: load_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: load_ray(to_q(rnd(-5.0, 5.0)), 0, 0, 0, 0, 0, 32'd655, 32'd0);
        4: load_ray(to_q(rnd(-100.0, 100.0)), to_q(rnd(-100.0, 100.0)), 0,
                    to_q(dx / n), to_q(dy / n), to_q(dz / n), 32'd6554, 32'd65536);
        default: load_ray(0, to_q(rnd(-3.0, 3.0)), 32'h0010_0000, 0, 0, 32'hFFFF_0000,
                          32'd2000, 32'd20000);
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        it = ($urandom_range(99) < 80) ? shaped_item() : noise_item();
        send_item(it, 0, none);
      end
      item_if.valid <= 1'b0;
    end

    while (hit_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d results (%0d hits, %0d segments) over %0d ray settings",
             results_seen, hits_seen, segments_sent, NUM_PHASES + 1);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
